// ===== hdl/q2e_pkg.sv =====
// Shared constants, widths and the arctangent table of the quaternion to Euler angle unit.
// No dependencies; every other file in hdl imports this package.
package q2e_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    // Vector and angle widths in the CORDIC, angles in Q.20 radians.
    localparam int CW = 37;
    localparam int AW = 25;

    // Integer square root of a 58-bit radicand, one result bit per stage.
    localparam int SQ_STEPS = 29;
    localparam int SQ_IN_W  = 58;
    localparam int SQ_W     = 60;
    localparam int RT_W     = 29;

    localparam int LATENCY = 2 + SQ_STEPS + 1 + CORDIC_N + 1;

    localparam logic signed [AW-1:0] ANG_PI      = AW'(3294199);
    localparam logic signed [AW-1:0] ANG_PI_HALF = AW'(1647099);
    localparam logic signed [15:0]   OUT_PI      = 16'sd25736;
    localparam logic signed [15:0]   OUT_PI_HALF = 16'sd12868;

    // round(atan(2^-i) * 2^20)
    function automatic logic signed [AW-1:0] atan_q20(input int idx);
        logic signed [AW-1:0] v;
        case (idx)
            0:  v = AW'(823550);
            1:  v = AW'(486170);
            2:  v = AW'(256879);
            3:  v = AW'(130396);
            4:  v = AW'(65451);
            5:  v = AW'(32757);
            6:  v = AW'(16383);
            7:  v = AW'(8192);
            8:  v = AW'(4096);
            9:  v = AW'(2048);
            10: v = AW'(1024);
            11: v = AW'(512);
            12: v = AW'(256);
            13: v = AW'(128);
            14: v = AW'(64);
            15: v = AW'(32);
            16: v = AW'(16);
            17: v = AW'(8);
            18: v = AW'(4);
            19: v = AW'(2);
            20: v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/q2e_isqrt.sv =====
// Pipelined floor integer square root, one result bit per register stage.
// Depends on q2e_pkg for widths and stage count.
module q2e_isqrt
    import q2e_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SQ_IN_W-1:0] i_radicand,
    output logic [RT_W-1:0]    o_root
);

    logic [SQ_W-1:0] r_rem [0:SQ_STEPS];
    logic [SQ_W-1:0] r_res [0:SQ_STEPS];

    assign r_rem[0] = SQ_W'(i_radicand);
    assign r_res[0] = '0;

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++) begin : g_step
            localparam logic [SQ_W-1:0] BIT =
                {{(SQ_W-1){1'b0}}, 1'b1} << (2 * (SQ_STEPS - 1 - k));
            logic [SQ_W-1:0] trial;
            assign trial = r_res[k] + BIT;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_rem[k] >= trial) begin
                        r_rem[k+1] <= r_rem[k] - trial;
                        r_res[k+1] <= (r_res[k] >> 1) + BIT;
                    end else begin
                        r_rem[k+1] <= r_rem[k];
                        r_res[k+1] <= r_res[k] >> 1;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_res[SQ_STEPS][RT_W-1:0];

endmodule

// ===== hdl/q2e_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(num, den) in Q.20 radians.
// Depends on q2e_pkg for widths, step count and the arctangent table.
module q2e_cordic
    import q2e_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_num,
    input  logic signed [CW-1:0] i_den,
    output logic signed [AW-1:0] o_angle
);

    logic signed [CW-1:0] r_x [0:CORDIC_N];
    logic signed [CW-1:0] r_y [0:CORDIC_N];
    logic signed [AW-1:0] r_a [0:CORDIC_N];
    logic                 r_z [0:CORDIC_N];

    // Pre-rotation by pi puts the vector in the right half plane.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0] <= (i_num == '0) && (i_den == '0);
            if (i_den < 0) begin
                r_x[0] <= -i_den;
                r_y[0] <= -i_num;
                r_a[0] <= (i_num >= 0) ? ANG_PI : -ANG_PI;
            end else begin
                r_x[0] <= i_den;
                r_y[0] <= i_num;
                r_a[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_N; i++) begin : g_rot
            localparam logic signed [AW-1:0] ATAN = atan_q20(i);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[i+1] <= r_z[i];
                    if (r_y[i] > 0) begin
                        r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                        r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                        r_a[i+1] <= r_a[i] + ATAN;
                    end else begin
                        r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                        r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                        r_a[i+1] <= r_a[i] - ATAN;
                    end
                end
            end
        end
    endgenerate

    assign o_angle = r_z[CORDIC_N] ? '0 : r_a[CORDIC_N];

endmodule

// ===== hdl/quaternion_to_euler_angles_unit.sv =====
// Top level of the quaternion to roll, pitch and yaw converter.
// Depends on q2e_pkg, q2e_isqrt and q2e_cordic.
//
// The unit takes one quaternion per transfer on the slave stream and returns its roll, pitch
// and yaw in radians, signed Q3.13, on the master stream. It is a fully pipelined datapath:
// one quaternion can be accepted every clock cycle while the master side does not stall. The
// depth is set by the 29 one-bit stages of the pitch square roots followed by the CORDIC
// rotation stages. Roll and yaw wait in a delay line beside the square roots so that all
// three arctangents run side by side. The whole pipeline advances together; when the master
// side stalls with a result waiting, the pipeline holds and s_axis_tready drops, so nothing
// is lost or repeated. Inputs outside +-1.0 are taken as their two's complement value and
// the angles saturate to +-pi for roll and yaw and +-pi/2 for pitch.
module quaternion_to_euler_angles_unit
    import q2e_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // roll[15:0], pitch[30:16], yaw[46:31], zero pad[47]
);

    logic en;
    logic r_vld [0:LATENCY-1];

    assign en            = !r_vld[LATENCY-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[LATENCY-1];

    // The valid bit travels beside the data through every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LATENCY; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int j = 1; j < LATENCY; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    // Stage 1: the nine component products that the angles use, exact in Q2.28.
    logic signed [15:0] qx, qy, qz, qw;
    assign qx = s_axis_tdata[15:0];
    assign qy = s_axis_tdata[31:16];
    assign qz = s_axis_tdata[47:32];
    assign qw = s_axis_tdata[63:48];

    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_xz, r_wz, r_xy, r_zz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= qw * qx;
            r_yz <= qy * qz;
            r_xx <= qx * qx;
            r_yy <= qy * qy;
            r_wy <= qw * qy;
            r_xz <= qx * qz;
            r_wz <= qw * qz;
            r_xy <= qx * qy;
            r_zz <= qz * qz;
        end
    end

    // Stage 2: atan2 arguments and the clamped square-root arguments of pitch.
    localparam logic signed [CW-1:0] ONE_Q28 = CW'(64'sd268435456);
    localparam logic signed [CW-1:0] TWO_Q28 = CW'(64'sd536870912);

    logic signed [CW-1:0] n_sr, n_cr, n_sy, n_cy, s_pitch, pa_raw, pb_raw;
    logic [29:0]          n_pa, n_pb;

    always_comb begin
        n_sr    = (CW'(r_wx) + CW'(r_yz)) <<< 1;
        n_cr    = ONE_Q28 - ((CW'(r_xx) + CW'(r_yy)) <<< 1);
        n_sy    = (CW'(r_wz) + CW'(r_xy)) <<< 1;
        n_cy    = ONE_Q28 - ((CW'(r_yy) + CW'(r_zz)) <<< 1);
        s_pitch = (CW'(r_wy) - CW'(r_xz)) <<< 1;
        pa_raw  = ONE_Q28 + s_pitch;
        pb_raw  = ONE_Q28 - s_pitch;
        if (pa_raw < 0) begin
            n_pa = '0;
        end else if (pa_raw > TWO_Q28) begin
            n_pa = TWO_Q28[29:0];
        end else begin
            n_pa = pa_raw[29:0];
        end
        if (pb_raw < 0) begin
            n_pb = '0;
        end else if (pb_raw > TWO_Q28) begin
            n_pb = TWO_Q28[29:0];
        end else begin
            n_pb = pb_raw[29:0];
        end
    end

    logic signed [CW-1:0] r_sr, r_cr, r_sy, r_cy;
    logic [29:0]          r_pa, r_pb;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr <= n_sr;
            r_cr <= n_cr;
            r_sy <= n_sy;
            r_cy <= n_cy;
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
    end

    // Square roots of the pitch arguments, Q.28 results.
    logic [RT_W-1:0] root_a, root_b;

    q2e_isqrt u_sqrt_a (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_radicand ({r_pa, 28'd0}),
        .o_root     (root_a)
    );

    q2e_isqrt u_sqrt_b (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_radicand ({r_pb, 28'd0}),
        .o_root     (root_b)
    );

    // Roll and yaw arguments wait while the square roots are formed.
    logic signed [CW-1:0] r_dsr [0:SQ_STEPS-1];
    logic signed [CW-1:0] r_dcr [0:SQ_STEPS-1];
    logic signed [CW-1:0] r_dsy [0:SQ_STEPS-1];
    logic signed [CW-1:0] r_dcy [0:SQ_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dsr[0] <= r_sr;
            r_dcr[0] <= r_cr;
            r_dsy[0] <= r_sy;
            r_dcy[0] <= r_cy;
            for (int j = 1; j < SQ_STEPS; j++) begin
                r_dsr[j] <= r_dsr[j-1];
                r_dcr[j] <= r_dcr[j-1];
                r_dsy[j] <= r_dsy[j-1];
                r_dcy[j] <= r_dcy[j-1];
            end
        end
    end

    logic signed [AW-1:0] ang_roll, ang_pitch, ang_yaw;

    q2e_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (r_dsr[SQ_STEPS-1]),
        .i_den   (r_dcr[SQ_STEPS-1]),
        .o_angle (ang_roll)
    );

    q2e_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (signed'(CW'(root_a))),
        .i_den   (signed'(CW'(root_b))),
        .o_angle (ang_pitch)
    );

    q2e_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (r_dsy[SQ_STEPS-1]),
        .i_den   (r_dcy[SQ_STEPS-1]),
        .o_angle (ang_yaw)
    );

    // Final stage: Q.20 to Q3.13 with round half up, then saturation.
    function automatic logic signed [15:0] to_q13(input logic signed [AW+1:0] v,
                                                   input logic signed [15:0]   lim);
        logic signed [AW+1:0] r;
        logic signed [AW+1:0] l;
        r = (v + (AW+2)'(64)) >>> 7;
        l = (AW+2)'(lim);
        if (r > l) begin
            r = l;
        end else if (r < -l) begin
            r = -l;
        end
        return r[15:0];
    endfunction

    logic signed [AW+1:0] pitch_full;
    logic signed [15:0]   n_roll, n_pitch, n_yaw;
    assign pitch_full = ((AW+2)'(ang_pitch) <<< 1) - (AW+2)'(ANG_PI_HALF);
    assign n_roll     = to_q13((AW+2)'(ang_roll), OUT_PI);
    assign n_pitch    = to_q13(pitch_full, OUT_PI_HALF);
    assign n_yaw      = to_q13((AW+2)'(ang_yaw), OUT_PI);

    logic [15:0] r_roll, r_yaw;
    logic [14:0] r_pitch;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= n_roll;
            r_pitch <= n_pitch[14:0];
            r_yaw   <= n_yaw;
        end
    end

    assign m_axis_tdata = {1'b0, r_yaw, r_pitch, r_roll};

endmodule
